[hdl/cse_pkg.sv]
`timescale 1ns / 1ps

package cse_pkg;

    localparam int PAYLOAD_BITS = 64;
    localparam int WORD_BITS    = 64;
    localparam int LEN_BITS     = 7;
    localparam int START_BITS   = 6;
    localparam int FACTOR_BITS  = 32;
    localparam int OFFSET_BITS  = 48;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 48;

    localparam logic [WORD_BITS-1:0] PAYLOAD_MASK =
        (PAYLOAD_BITS >= WORD_BITS) ? {WORD_BITS{1'b1}}
                                    : ~({WORD_BITS{1'b1}} << PAYLOAD_BITS);

    localparam logic [CFG_IDX_BITS-1:0] REG_START_BIT      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BIT_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOTOROLA_ORDER = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_IS_SIGNED      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_FACTOR   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_OFFSET   = 3'd5;

    localparam logic [START_BITS-1:0]  RST_START_BIT    = 6'd0;
    localparam logic [LEN_BITS-1:0]    RST_BIT_LENGTH   = 7'd8;
    localparam logic [FACTOR_BITS-1:0] RST_SCALE_FACTOR = 32'h0001_0000;
    localparam logic [OFFSET_BITS-1:0] RST_SCALE_OFFSET = 48'd0;

    typedef struct packed {
        logic [START_BITS-1:0]  start_bit;
        logic [LEN_BITS-1:0]    bit_length;
        logic                   motorola_order;
        logic                   is_signed;
        logic [FACTOR_BITS-1:0] scale_factor;
        logic [OFFSET_BITS-1:0] scale_offset;
    } cfg_t;

endpackage

[hdl/cse_extract.sv]
`timescale 1ns / 1ps

module cse_extract
(
    input  logic                            clk,
    input  logic                            en,
    input  cse_pkg::cfg_t                   cfg,
    input  logic [cse_pkg::WORD_BITS-1:0]   payload,
    output logic [cse_pkg::WORD_BITS-1:0]   raw
);

    logic [cse_pkg::WORD_BITS-1:0] pay_reg;
    logic [cse_pkg::WORD_BITS-1:0] win_reg;
    logic [cse_pkg::WORD_BITS-1:0] win_next;
    logic [cse_pkg::WORD_BITS-1:0] raw_reg;
    logic [cse_pkg::WORD_BITS-1:0] raw_next;
    logic [cse_pkg::LEN_BITS-1:0]  len;
    logic [cse_pkg::LEN_BITS-1:0]  rshift;
    logic [cse_pkg::WORD_BITS-1:0] len_mask;
    logic [cse_pkg::WORD_BITS-1:0] rev;
    logic [cse_pkg::WORD_BITS-1:0] ordered;
    logic                          top_bit;

    // clamp length to one word
    always_comb
    begin
        if (cfg.bit_length > cse_pkg::LEN_BITS'(cse_pkg::WORD_BITS))
        begin
            len = cse_pkg::LEN_BITS'(cse_pkg::WORD_BITS);
        end
        else
        begin
            len = cfg.bit_length;
        end
        len_mask = ~({cse_pkg::WORD_BITS{1'b1}} << len);
        rshift   = cse_pkg::LEN_BITS'(cse_pkg::WORD_BITS) - len;
    end

    // window of len bits starting at start_bit
    assign win_next = ((pay_reg & cse_pkg::PAYLOAD_MASK) >> cfg.start_bit) & len_mask;

    // motorola: first gathered bit becomes msb
    always_comb
    begin
        for (int i = 0; i < cse_pkg::WORD_BITS; i++)
        begin
            rev[i] = win_reg[cse_pkg::WORD_BITS-1-i];
        end
        if (cfg.motorola_order)
        begin
            ordered = rev >> rshift;
        end
        else
        begin
            ordered = win_reg;
        end
        top_bit = |(ordered & ~(len_mask >> 1) & len_mask);
        if (cfg.is_signed && top_bit && (len != cse_pkg::LEN_BITS'(cse_pkg::WORD_BITS)))
        begin
            raw_next = ordered | ~len_mask;
        end
        else
        begin
            raw_next = ordered;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg <= payload;
            win_reg <= win_next;
            raw_reg <= raw_next;
        end
    end

    assign raw = raw_reg;

endmodule

[hdl/cse_scale.sv]
`timescale 1ns / 1ps

module cse_scale
(
    input  logic                            clk,
    input  logic                            en,
    input  cse_pkg::cfg_t                   cfg,
    input  logic [cse_pkg::WORD_BITS-1:0]   raw_in,
    output logic [cse_pkg::WORD_BITS-1:0]   raw_value,
    output logic [cse_pkg::WORD_BITS-1:0]   scaled_value,
    output logic                            overflow
);

    localparam int HALF    = cse_pkg::WORD_BITS / 2;
    localparam int PL_BITS = HALF + 1 + cse_pkg::FACTOR_BITS;
    localparam int PH_BITS = HALF + cse_pkg::FACTOR_BITS;
    localparam int SUM_BITS = cse_pkg::WORD_BITS + cse_pkg::FACTOR_BITS + 1;

    logic [cse_pkg::WORD_BITS-1:0] rawd_reg;
    logic signed [PL_BITS-1:0]     pl_reg;
    logic signed [PL_BITS-1:0]     pl_next;
    logic signed [PH_BITS-1:0]     ph_reg;
    logic signed [PH_BITS-1:0]     ph_next;
    logic signed [HALF:0]          lo_op;
    logic signed [HALF-1:0]        hi_op;
    logic signed [cse_pkg::FACTOR_BITS-1:0] factor;
    logic [SUM_BITS-1:0]           sum;
    logic                          fits;
    logic [cse_pkg::WORD_BITS-1:0] raw_out_reg;
    logic [cse_pkg::WORD_BITS-1:0] scaled_reg;
    logic [cse_pkg::WORD_BITS-1:0] scaled_next;
    logic                          ovf_reg;

    // split 64x32 product into a 33x32 (zero-extended low half) and a 32x32 partial product
    always_comb
    begin
        lo_op   = $signed({1'b0, raw_in[HALF-1:0]});
        hi_op   = $signed(raw_in[cse_pkg::WORD_BITS-1:HALF]);
        factor  = $signed(cfg.scale_factor);
        pl_next = PL_BITS'(lo_op * factor);
        ph_next = PH_BITS'(hi_op * factor);
    end

    // recombine, add offset, saturate
    always_comb
    begin
        sum = {ph_reg[PH_BITS-1], ph_reg, {HALF{1'b0}}}
            + {{(SUM_BITS-PL_BITS){pl_reg[PL_BITS-1]}}, pl_reg}
            + {{(SUM_BITS-cse_pkg::OFFSET_BITS){cfg.scale_offset[cse_pkg::OFFSET_BITS-1]}},
               cfg.scale_offset};
        fits = (&sum[SUM_BITS-1:cse_pkg::WORD_BITS-1]) || ~(|sum[SUM_BITS-1:cse_pkg::WORD_BITS-1]);
        if (fits)
        begin
            scaled_next = sum[cse_pkg::WORD_BITS-1:0];
        end
        else if (sum[SUM_BITS-1])
        begin
            scaled_next = {1'b1, {(cse_pkg::WORD_BITS-1){1'b0}}};
        end
        else
        begin
            scaled_next = {1'b0, {(cse_pkg::WORD_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rawd_reg    <= raw_in;
            pl_reg      <= pl_next;
            ph_reg      <= ph_next;
            raw_out_reg <= rawd_reg;
            scaled_reg  <= scaled_next;
            ovf_reg     <= ~fits;
        end
    end

    assign raw_value    = raw_out_reg;
    assign scaled_value = scaled_reg;
    assign overflow     = ovf_reg;

endmodule

[hdl/can_signal_extract_scale.sv]
`timescale 1ns / 1ps

// decodes one signal from each 64-bit frame payload: gathers bit_length bits
// from start_bit (intel or motorola order), sign-extends if asked, and forms
// raw * scale_factor + scale_offset in signed q.16 with saturation and an
// overflow flag. one item per cycle when the output is not stalled; each item
// passes through five registers (input, window, raw, partial product and
// result). the whole pipeline holds while a result waits on m_axis_tready. the user
// must write configuration only while no item is in flight; the block does not check it.

module can_signal_extract_scale
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [63:0]                         s_axis_tdata,   // payload

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [127:0]                        m_axis_tdata,   // raw_value, scaled_value
    output logic [0:0]                          m_axis_tuser,   // overflow

    input  logic                                cfg_we,
    input  logic [cse_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [cse_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int STAGES = 5;

    cse_pkg::cfg_t                  cfg_reg;
    logic [STAGES-1:0]              vld_reg;
    logic                           en;
    logic [cse_pkg::WORD_BITS-1:0]  raw;
    logic [cse_pkg::WORD_BITS-1:0]  raw_value;
    logic [cse_pkg::WORD_BITS-1:0]  scaled_value;
    logic                           overflow;

    assign en            = ~vld_reg[STAGES-1] | m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[STAGES-1];
    assign m_axis_tdata  = {scaled_value, raw_value};
    assign m_axis_tuser  = overflow;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg                <= '0;
            cfg_reg.start_bit      <= cse_pkg::RST_START_BIT;
            cfg_reg.bit_length     <= cse_pkg::RST_BIT_LENGTH;
            cfg_reg.motorola_order <= 1'b0;
            cfg_reg.is_signed      <= 1'b0;
            cfg_reg.scale_factor   <= cse_pkg::RST_SCALE_FACTOR;
            cfg_reg.scale_offset   <= cse_pkg::RST_SCALE_OFFSET;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[STAGES-2:0], s_axis_tvalid};
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    cse_pkg::REG_START_BIT:
                        cfg_reg.start_bit <= cfg_data[cse_pkg::START_BITS-1:0];
                    cse_pkg::REG_BIT_LENGTH:
                        cfg_reg.bit_length <= cfg_data[cse_pkg::LEN_BITS-1:0];
                    cse_pkg::REG_MOTOROLA_ORDER:
                        cfg_reg.motorola_order <= cfg_data[0];
                    cse_pkg::REG_IS_SIGNED:
                        cfg_reg.is_signed <= cfg_data[0];
                    cse_pkg::REG_SCALE_FACTOR:
                        cfg_reg.scale_factor <= cfg_data[cse_pkg::FACTOR_BITS-1:0];
                    cse_pkg::REG_SCALE_OFFSET:
                        cfg_reg.scale_offset <= cfg_data[cse_pkg::OFFSET_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    cse_extract u_extract
    (
        .clk     (clk),
        .en      (en),
        .cfg     (cfg_reg),
        .payload (s_axis_tdata),
        .raw     (raw)
    );

    cse_scale u_scale
    (
        .clk          (clk),
        .en           (en),
        .cfg          (cfg_reg),
        .raw_in       (raw),
        .raw_value    (raw_value),
        .scaled_value (scaled_value),
        .overflow     (overflow)
    );

endmodule

[sim/tb_can_signal_extract_scale.sv]
`timescale 1ns / 1ps

module tb_can_signal_extract_scale;

    import cse_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS_PER_PHASE = 484;
    localparam int PIPE_DRAIN = 6;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_HI = 3'd7;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN  = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0] raw_value;
        logic [63:0] scaled_value;
        logic        overflow;
    } decode_t;

    typedef struct {
        cfg_t        cfg;
        logic [63:0] payload;
        bit          typed;
        decode_t     want;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [63:0]              s_axis_tdata = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [127:0]             m_axis_tdata;
    logic [0:0]               m_axis_tuser;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    cfg_t       cur_cfg;
    decode_t    pending_decodes[$];
    decode_t    head;
    stim_row_t  directed_rows[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    can_signal_extract_scale uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic cfg_t make_cfg(input logic [5:0] start, input logic [6:0] len,
                                      input logic moto, input logic sgn,
                                      input logic [31:0] factor, input logic [47:0] offset);
        cfg_t c;
        c.start_bit      = start;
        c.bit_length     = len;
        c.motorola_order = moto;
        c.is_signed      = sgn;
        c.scale_factor   = factor;
        c.scale_offset   = offset;
        return c;
    endfunction

    // gather the signal bits, extend, then raw * factor + offset at 128 bits and saturate
    function automatic decode_t decode_frame(input logic [63:0] payload, input cfg_t c);
        decode_t            d;
        int                 len;
        int                 pos;
        int                 i;
        logic [63:0]        raw;
        logic signed [127:0] wide_raw;
        logic signed [127:0] wide_factor;
        logic signed [127:0] wide_offset;
        logic signed [127:0] sum;
        len = (c.bit_length > 7'd64) ? 64 : int'(c.bit_length);
        raw = '0;
        for (i = 0; i < len; i++)
        begin
            pos = int'(c.start_bit) + i;
            if (pos < PAYLOAD_BITS && pos < 64)
            begin
                if (c.motorola_order)
                    raw[len-1-i] = payload[pos];
                else
                    raw[i] = payload[pos];
            end
        end
        if (c.is_signed && len >= 1 && len < 64 && raw[len-1])
        begin
            for (i = len; i < 64; i++)
                raw[i] = 1'b1;
        end
        wide_raw    = $signed(raw);
        wide_factor = $signed(c.scale_factor);
        wide_offset = $signed(c.scale_offset);
        sum = wide_raw * wide_factor + wide_offset;
        d.raw_value = raw;
        if (sum[127:63] == {65{sum[127]}})
        begin
            d.scaled_value = sum[63:0];
            d.overflow     = 1'b0;
        end
        else
        begin
            d.scaled_value = sum[127] ? SAT_MIN : SAT_MAX;
            d.overflow     = 1'b1;
        end
        return d;
    endfunction

    task automatic add_row(input cfg_t c, input logic [63:0] payload, input bit typed,
                           input logic [63:0] raw, input logic [63:0] scaled,
                           input logic ovf);
        stim_row_t r;
        r.cfg     = c;
        r.payload = payload;
        r.typed   = typed;
        r.want    = '{raw_value: raw, scaled_value: scaled, overflow: ovf};
        directed_rows.insert(directed_rows.size(), r);
    endtask

    task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // only while nothing is in flight
    task automatic write_config(input cfg_t c);
        s_axis_tvalid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
        set_reg(REG_START_BIT, CFG_DATA_BITS'(c.start_bit));
        set_reg(REG_BIT_LENGTH, CFG_DATA_BITS'(c.bit_length));
        set_reg(REG_MOTOROLA_ORDER, CFG_DATA_BITS'(c.motorola_order));
        set_reg(REG_IS_SIGNED, CFG_DATA_BITS'(c.is_signed));
        set_reg(REG_SCALE_FACTOR, CFG_DATA_BITS'(c.scale_factor));
        set_reg(REG_SCALE_OFFSET, CFG_DATA_BITS'(c.scale_offset));
        // unused indexes must leave the registers alone
        if ($urandom_range(0, 2) == 0)
            set_reg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO,
                    CFG_DATA_BITS'({$urandom, $urandom}));
        cfg_we <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic send_payload(input logic [63:0] payload, input bit typed,
                                input decode_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= payload;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_decodes.insert(pending_decodes.size(),
                               typed ? want : decode_frame(payload, cur_cfg));
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_decodes.size() == 0)
            begin
                $error("result item with no item pending");
                mismatch_count++;
            end
            else
            begin
                head = pending_decodes.pop_front();
                if (m_axis_tdata[63:0] !== head.raw_value)
                begin
                    $error("raw_value expected %h got %h", head.raw_value, m_axis_tdata[63:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[127:64] !== head.scaled_value)
                begin
                    $error("scaled_value expected %h got %h", head.scaled_value,
                           m_axis_tdata[127:64]);
                    mismatch_count++;
                end
                if (m_axis_tuser[0] !== head.overflow)
                begin
                    $error("overflow expected %b got %b", head.overflow, m_axis_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        cfg_t        c;
        stim_row_t   r;
        logic [63:0] p;
        int          phase;
        int          left;
        int          n;

        cur_cfg = make_cfg(RST_START_BIT, RST_BIT_LENGTH, 1'b0, 1'b0,
                           RST_SCALE_FACTOR, RST_SCALE_OFFSET);

        // reset values first, then extremes, both orders, sign, saturation edges
        add_row(cur_cfg, 64'h0, 1, 64'h0, 64'h0, 1'b0);
        add_row(cur_cfg, ALL_ONES, 1, 64'hFF, 64'hFF_0000, 1'b0);
        add_row(cur_cfg, 64'h0123_4567_89AB_CDEF, 0, '0, '0, 1'b0);
        add_row(make_cfg(60, 8, 0, 0, 32'h0001_0000, 48'h0), ALL_ONES, 1,
                64'h0F, 64'h0F_0000, 1'b0);
        add_row(make_cfg(60, 8, 1, 0, 32'h0001_0000, 48'h0), ALL_ONES, 1,
                64'hF0, 64'hF0_0000, 1'b0);
        add_row(make_cfg(0, 8, 1, 0, 32'h0001_0000, 48'h0), 64'h01, 1,
                64'h80, 64'h80_0000, 1'b0);
        add_row(make_cfg(5, 11, 1, 1, 32'hFFFC_8000, 48'h0000_0001_8000),
                64'h5A3C_96E1_0F7B_D24C, 0, '0, '0, 1'b0);
        add_row(make_cfg(0, 8, 0, 1, 32'h0001_0000, 48'h0), 64'h80, 1,
                64'hFFFF_FFFF_FFFF_FF80, 64'hFFFF_FFFF_FF80_0000, 1'b0);
        add_row(make_cfg(0, 8, 0, 1, 32'h0001_0000, 48'h0), 64'h7F, 1,
                64'h7F, 64'h7F_0000, 1'b0);
        add_row(make_cfg(0, 0, 0, 0, 32'h0001_0000, 48'h8000_0000_0000), ALL_ONES, 1,
                64'h0, 64'hFFFF_8000_0000_0000, 1'b0);
        add_row(make_cfg(0, 127, 0, 0, 32'h0001_0000, 48'h0), 64'h0000_8000_0000_0000, 1,
                64'h0000_8000_0000_0000, SAT_MAX, 1'b1);
        add_row(make_cfg(0, 64, 0, 1, 32'h0001_0000, 48'h0), ALL_ONES, 1,
                ALL_ONES, 64'hFFFF_FFFF_FFFF_0000, 1'b0);
        add_row(make_cfg(0, 64, 0, 1, 32'h8000_0000, 48'h0), SAT_MIN, 1,
                SAT_MIN, SAT_MAX, 1'b1);
        add_row(make_cfg(0, 64, 0, 1, 32'h7FFF_FFFF, 48'h0), SAT_MIN, 1,
                SAT_MIN, SAT_MIN, 1'b1);
        add_row(make_cfg(0, 64, 0, 0, 32'h0, 48'h7FFF_FFFF_FFFF), 64'h0123_4567_89AB_CDEF, 1,
                64'h0123_4567_89AB_CDEF, 64'h0000_7FFF_FFFF_FFFF, 1'b0);
        add_row(make_cfg(0, 64, 0, 0, 32'h0001_0000, 48'h0000_0000_FFFF),
                64'h0000_7FFF_FFFF_FFFF, 1, 64'h0000_7FFF_FFFF_FFFF, SAT_MAX, 1'b0);
        add_row(make_cfg(0, 64, 0, 0, 32'h0001_0000, 48'h0000_0001_0000),
                64'h0000_7FFF_FFFF_FFFF, 1, 64'h0000_7FFF_FFFF_FFFF, SAT_MAX, 1'b1);
        add_row(make_cfg(0, 64, 0, 1, 32'h0001_0000, 48'h0), 64'hFFFF_8000_0000_0000, 1,
                64'hFFFF_8000_0000_0000, SAT_MIN, 1'b0);
        add_row(make_cfg(0, 64, 0, 1, 32'h0001_0000, 48'hFFFF_FFFF_FFFF),
                64'hFFFF_8000_0000_0000, 1, 64'hFFFF_8000_0000_0000, SAT_MIN, 1'b1);
        add_row(make_cfg(63, 1, 0, 1, 32'h0001_0000, 48'h0), SAT_MIN, 1,
                ALL_ONES, 64'hFFFF_FFFF_FFFF_0000, 1'b0);
        add_row(make_cfg(63, 64, 1, 0, 32'h0000_0003, 48'h0), 64'hC3A5_0F1E_7788_9ABC, 0,
                '0, '0, 1'b0);
        add_row(make_cfg(17, 33, 1, 1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF),
                64'h9E37_79B9_7F4A_7C15, 0, '0, '0, 1'b0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 19;
        recv_idle_pct = 75;
        foreach (directed_rows[k])
        begin
            r = directed_rows[k];
            if (r.cfg != cur_cfg)
                write_config(r.cfg);
            send_payload(r.payload, r.typed, r.want);
        end

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 19 : 0;
            left = RANDOM_ITEMS_PER_PHASE;
            while (left > 0)
            begin
                case ($urandom_range(0, 5))
                    0: c.start_bit = '0;
                    1: c.start_bit = 6'd63;
                    default: c.start_bit = 6'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0: c.bit_length = 7'd0;
                    1: c.bit_length = 7'd64;
                    2: c.bit_length = 7'($urandom_range(65, 127));
                    3: c.bit_length = 7'd1;
                    default: c.bit_length = 7'($urandom_range(1, 64));
                endcase
                c.motorola_order = 1'($urandom_range(0, 1));
                c.is_signed      = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 7))
                    0: c.scale_factor = 32'h8000_0000;
                    1: c.scale_factor = 32'h7FFF_FFFF;
                    2: c.scale_factor = 32'h0;
                    3: c.scale_factor = 32'h0001_0000;
                    4: c.scale_factor = $urandom_range(0, 1)
                                        ? 32'($urandom_range(0, 1 << 20))
                                        : -32'($urandom_range(0, 1 << 20));
                    default: c.scale_factor = $urandom;
                endcase
                case ($urandom_range(0, 5))
                    0: c.scale_offset = 48'h8000_0000_0000;
                    1: c.scale_offset = 48'h7FFF_FFFF_FFFF;
                    2: c.scale_offset = 48'h0;
                    default: c.scale_offset = 48'({$urandom, $urandom});
                endcase
                write_config(c);

                n = $urandom_range(10, 60);
                if (n > left)
                    n = left;
                left -= n;
                repeat (n)
                begin
                    case ($urandom_range(0, 9))
                        0: p = '0;
                        1: p = ALL_ONES;
                        2: p = 64'h1 << $urandom_range(0, 63);
                        default: p = {$urandom, $urandom};
                    endcase
                    send_payload(p, 1'b0, '0);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_DRAIN) @(posedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
